FILE: rtl/core/s2c_pkg.sv
// Shared types, constants and helpers of the spherical to Cartesian converter.
`timescale 1ns / 1ps
package s2c_pkg;

  localparam int unsigned TURN_W     = 16;
  localparam int unsigned AZ_DEG_W   = 9;
  localparam int unsigned COORD_W    = 17;
  localparam int unsigned CORDIC_W   = 33;
  localparam int unsigned TRIG_W     = 22;
  localparam int unsigned TRIG_SHIFT = 10;

  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // Q30 inverse CORDIC gain loaded as the start vector
  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 33'sd652032874;

  // Degrees to 16-bit turn: (deg * 65536 + 180) / 360 by reciprocal multiply.
  localparam logic [AZ_DEG_W-1:0] DEG_PER_TURN   = 9'd360;
  localparam logic [AZ_DEG_W-1:0] AZ_ROUND       = 9'd180;
  localparam int unsigned         AZ_NUM_W       = AZ_DEG_W + TURN_W;
  localparam int unsigned         AZ_PROD_W      = 2 * AZ_NUM_W;
  localparam int unsigned         AZ_RECIP_SHIFT = 33;
  localparam logic [AZ_NUM_W-1:0] AZ_RECIP       = 25'd23860930;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 17'sh0FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 17'sh10000;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > 64'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < 64'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/s2c_stream_if.sv
// Valid/ready channel interfaces for lidar points and Cartesian results.
`timescale 1ns / 1ps
interface s2c_point_if import s2c_pkg::*; #(parameter int unsigned RANGE_WIDTH = 18) ();
  logic                   valid;
  logic                   ready;
  logic [RANGE_WIDTH-1:0] range_q2;
  logic [TURN_W-1:0]      elevation_code;
  logic [AZ_DEG_W-1:0]    azimuth_degrees;

  modport source (output valid, range_q2, elevation_code, azimuth_degrees, input ready);
  modport sink   (input valid, range_q2, elevation_code, azimuth_degrees, output ready);
endinterface

interface s2c_xyz_if import s2c_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_mm;
  logic signed [COORD_W-1:0] z_mm;

  modport source (output valid, x_mm, y_mm, z_mm, input ready);
  modport sink   (input valid, x_mm, y_mm, z_mm, output ready);
endinterface

FILE: rtl/core/spherical_to_cartesian.sv
// Top level of the lidar spherical to Cartesian converter.
// Pipeline: ROTATION_STEPS + 8 register stages, with ROTATION_STEPS capped at ATAN_ENTRIES.
// Throughput: one item per cycle unless stalled; each CORDIC micro-rotation has its own stage.
// Stalls: every stage holds its own valid bit, so bubbles are squeezed out under back-pressure.
// Reset: rst_ni clears only the valid bits; datapath registers are not reset.
`timescale 1ns / 1ps
module spherical_to_cartesian import s2c_pkg::*; #(
  parameter int unsigned RANGE_WIDTH    = 18,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input logic         clk_i,
  input logic         rst_ni,
  s2c_point_if.sink   pt_i,
  s2c_xyz_if.source   xyz_o
);

  // The arctangent table bounds the number of usable micro-rotations.
  localparam int unsigned CORDIC_STEPS =
    (ROTATION_STEPS < ATAN_ENTRIES) ? ROTATION_STEPS : ATAN_ENTRIES;
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned SCALE_STAGES = 6;
  localparam int unsigned STAGES       = FRONT_STAGES + CORDIC_STEPS + SCALE_STAGES;

  logic [STAGES-1:0]      en;
  logic                   in_ready;
  logic                   out_valid;

  logic [RANGE_WIDTH-1:0] fr_range, cd_range;
  cordic_t                fr_el, fr_az, cd_el, cd_az;
  logic                   fr_el_flip, fr_az_flip, cd_el_flip, cd_az_flip;

  // Valid bits and load enables: a stage loads whenever it is empty or draining.
  s2c_ctrl #(
    .STAGES(STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .out_ready_i(xyz_o.ready),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .en_o       (en)
  );

  assign pt_i.ready  = in_ready;
  assign xyz_o.valid = out_valid;

  // Stages 0 and 1: degrees to 16-bit turn, then fold both angles into the right half plane.
  s2c_front #(
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (en[FRONT_STAGES-1:0]),
    .range_i  (pt_i.range_q2[RANGE_WIDTH-1:0]),
    .elev_i   (pt_i.elevation_code),
    .az_deg_i (pt_i.azimuth_degrees),
    .range_o  (fr_range),
    .el_o     (fr_el),
    .el_flip_o(fr_el_flip),
    .az_o     (fr_az),
    .az_flip_o(fr_az_flip)
  );

  // Elevation CORDIC; the range and the elevation fold flag ride along.
  s2c_cordic #(
    .STEPS (CORDIC_STEPS),
    .SIDE_W(RANGE_WIDTH + 1)
  ) u_cordic_el (
    .clk_i  (clk_i),
    .en_i   (en[FRONT_STAGES +: CORDIC_STEPS]),
    .state_i(fr_el),
    .side_i ({fr_el_flip, fr_range}),
    .state_o(cd_el),
    .side_o ({cd_el_flip, cd_range})
  );

  // Azimuth CORDIC, in lockstep with the elevation one.
  s2c_cordic #(
    .STEPS (CORDIC_STEPS),
    .SIDE_W(1)
  ) u_cordic_az (
    .clk_i  (clk_i),
    .en_i   (en[FRONT_STAGES +: CORDIC_STEPS]),
    .state_i(fr_az),
    .side_i (fr_az_flip),
    .state_o(cd_az),
    .side_o (cd_az_flip)
  );

  // Last six stages: trig to Q20, range products, truncate toward zero, saturate.
  // The final stage registers double as the output register.
  s2c_scale #(
    .RANGE_WIDTH(RANGE_WIDTH)
  ) u_scale (
    .clk_i    (clk_i),
    .en_i     (en[STAGES-1 -: SCALE_STAGES]),
    .range_i  (cd_range),
    .el_i     (cd_el),
    .el_flip_i(cd_el_flip),
    .az_i     (cd_az),
    .az_flip_i(cd_az_flip),
    .x_o      (xyz_o.x_mm),
    .y_o      (xyz_o.y_mm),
    .z_o      (xyz_o.z_mm)
  );

endmodule

FILE: rtl/core/s2c_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
`timescale 1ns / 1ps
module s2c_ctrl #(
  parameter int unsigned STAGES = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output logic [STAGES-1:0] en_o
);

  logic [STAGES-1:0] valid_q, valid_d;
  logic [STAGES:0]   ready;
  logic              in_fire, out_fire;

  // A stage may load when it is empty or its item moves on this cycle.
  assign ready[STAGES] = out_ready_i;
  for (genvar k = 0; k < STAGES; k++) begin : g_ready
    assign ready[k] = ~valid_q[k] | ready[k+1];
  end

  assign valid_d     = {valid_q[STAGES-2:0], in_valid_i};
  assign en_o        = ready[STAGES-1:0];
  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[STAGES-1];
  assign in_fire     = in_valid_i & ready[0];
  assign out_fire    = valid_q[STAGES-1] & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= (valid_d & en_o) | (valid_q & ~en_o);
    end
  end

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
    else $error("item count did not grow on accept");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !in_fire) |=> $countones(valid_q) + 1 == $past($countones(valid_q)))
    else $error("item count did not shrink on delivery");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire == out_fire) |=> $countones(valid_q) == $past($countones(valid_q)))
    else $error("item count changed without a transfer");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

endmodule

FILE: rtl/core/s2c_front.sv
// Front stages: azimuth degrees to turn fraction and quadrant folding of both angles.
`timescale 1ns / 1ps
module s2c_front import s2c_pkg::*; #(
  parameter int unsigned RANGE_WIDTH = 18
) (
  input  logic                   clk_i,
  input  logic [1:0]             en_i,
  input  logic [RANGE_WIDTH-1:0] range_i,
  input  logic [TURN_W-1:0]      elev_i,
  input  logic [AZ_DEG_W-1:0]    az_deg_i,
  output logic [RANGE_WIDTH-1:0] range_o,
  output cordic_t                el_o,
  output logic                   el_flip_o,
  output cordic_t                az_o,
  output logic                   az_flip_o
);

  function automatic logic fold_flip(input logic [TURN_W-1:0] t);
    return t[TURN_W-1] ^ t[TURN_W-2];
  endfunction

  // Move quadrants 1 and 2 by half a turn; the result gets negated later.
  function automatic cordic_t fold(input logic [TURN_W-1:0] t);
    cordic_t     s;
    logic [31:0] u;
    u   = {t[TURN_W-1] ^ fold_flip(t), t[TURN_W-2:0], 16'd0};
    s.x = INV_GAIN_Q30;
    s.y = '0;
    s.z = signed'({u[31], u});
    return s;
  endfunction

  logic [AZ_DEG_W-1:0]    deg_wrap;
  logic [AZ_NUM_W-1:0]    az_num;
  logic [AZ_PROD_W-1:0]   az_prod_d, az_prod_q;
  logic [RANGE_WIDTH-1:0] range0_q, range1_q;
  logic [TURN_W-1:0]      elev0_q, az_turn;
  cordic_t                el_d, el_q, az_d, az_q;
  logic                   el_flip_q, az_flip_q;

  always_comb begin
    deg_wrap  = (az_deg_i >= DEG_PER_TURN) ? az_deg_i - DEG_PER_TURN : az_deg_i;
    az_num    = {deg_wrap, {TURN_W{1'b0}}} + AZ_NUM_W'(AZ_ROUND);
    az_prod_d = AZ_PROD_W'(az_num) * AZ_PROD_W'(AZ_RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      az_prod_q <= az_prod_d;
      range0_q  <= range_i;
      elev0_q   <= elev_i;
    end
  end

  always_comb begin
    az_turn = az_prod_q[AZ_RECIP_SHIFT +: TURN_W];
    el_d    = fold(elev0_q);
    az_d    = fold(az_turn);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      el_q      <= el_d;
      az_q      <= az_d;
      el_flip_q <= fold_flip(elev0_q);
      az_flip_q <= fold_flip(az_turn);
      range1_q  <= range0_q;
    end
  end

  assign range_o   = range1_q;
  assign el_o      = el_q;
  assign el_flip_o = el_flip_q;
  assign az_o      = az_q;
  assign az_flip_o = az_flip_q;

endmodule

FILE: rtl/core/s2c_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per register stage, with a sideband delay line.
`timescale 1ns / 1ps
module s2c_cordic import s2c_pkg::*; #(
  parameter int unsigned STEPS  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic [STEPS-1:0]  en_i,
  input  cordic_t           state_i,
  input  logic [SIDE_W-1:0] side_i,
  output cordic_t           state_o,
  output logic [SIDE_W-1:0] side_o
);

  function automatic cordic_t rotate(input cordic_t s, input logic [ATAN_IDX_W-1:0] k);
    cordic_t                    n;
    logic signed [CORDIC_W-1:0] dx, dy, da;
    dx = s.y >>> k;
    dy = s.x >>> k;
    da = signed'(CORDIC_W'(ATAN_TURN32[k]));
    if (s.z[CORDIC_W-1]) begin
      n.x = s.x + dx;
      n.y = s.y - dy;
      n.z = s.z + da;
    end else begin
      n.x = s.x - dx;
      n.y = s.y + dy;
      n.z = s.z - da;
    end
    return n;
  endfunction

  cordic_t           st_out   [STEPS];
  logic [SIDE_W-1:0] side_out [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cordic_t           prev_st, st_d, st_q;
    logic [SIDE_W-1:0] prev_side, side_q;

    if (k == 0) begin : g_first
      assign prev_st   = state_i;
      assign prev_side = side_i;
    end else begin : g_next
      assign prev_st   = st_out[k-1];
      assign prev_side = side_out[k-1];
    end

    assign st_d = rotate(prev_st, ATAN_IDX_W'(k));

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q   <= st_d;
        side_q <= prev_side;
      end
    end

    assign st_out[k]   = st_q;
    assign side_out[k] = side_q;
  end

  assign state_o = st_out[STEPS-1];
  assign side_o  = side_out[STEPS-1];

endmodule

FILE: rtl/core/s2c_scale.sv
// Back stages: Q20 trig values, range products, truncation and saturation to millimetres.
`timescale 1ns / 1ps
module s2c_scale import s2c_pkg::*; #(
  parameter int unsigned RANGE_WIDTH = 18
) (
  input  logic                      clk_i,
  input  logic [5:0]                en_i,
  input  logic [RANGE_WIDTH-1:0]    range_i,
  input  cordic_t                   el_i,
  input  logic                      el_flip_i,
  input  cordic_t                   az_i,
  input  logic                      az_flip_i,
  output logic signed [COORD_W-1:0] x_o,
  output logic signed [COORD_W-1:0] y_o,
  output logic signed [COORD_W-1:0] z_o
);

  localparam int unsigned RW    = RANGE_WIDTH;
  localparam int unsigned PR_W  = RW + TRIG_W + 1;
  localparam int unsigned RC_W  = PR_W - 4;
  localparam int unsigned LO_W  = 20;
  localparam int unsigned HI_W  = RC_W - LO_W;
  localparam int unsigned PL_W  = LO_W + 1 + TRIG_W;
  localparam int unsigned PH_W  = HI_W + TRIG_W;
  localparam int unsigned SUM_W = RW + 41;
  localparam int unsigned Z_SH  = 22;
  localparam int unsigned XY_SH = 38;

  // Negate for folded quadrants, then cut Q30 to Q20 toward zero.
  function automatic logic signed [TRIG_W-1:0] to_q20(input logic signed [CORDIC_W-1:0] v,
                                                      input logic flip);
    logic signed [CORDIC_W-1:0] n, b, sh;
    n  = flip ? -v : v;
    b  = n[CORDIC_W-1] ? n + CORDIC_W'({TRIG_SHIFT{1'b1}}) : n;
    sh = b >>> TRIG_SHIFT;
    return sh[TRIG_W-1:0];
  endfunction

  // stage 0
  logic signed [TRIG_W-1:0] ce_q, se_q, ca_q, sa_q;
  logic [RW-1:0]            r0_q;
  // stage 1
  logic signed [PR_W-1:0]   p_rc_d, p_rc_q, p_z_d, p_z_q;
  logic signed [TRIG_W-1:0] ca1_q, sa1_q;
  logic signed [RW:0]       r_s;
  // stage 2
  logic signed [PR_W-1:0]    t_rc, t_z, q_z;
  logic signed [RC_W-1:0]    rc_d, rc_q;
  logic signed [COORD_W-1:0] z2_d, z2_q;
  logic signed [TRIG_W-1:0]  ca2_q, sa2_q;
  // stage 3
  logic signed [HI_W-1:0]    rc_hi;
  logic signed [LO_W:0]      rc_lo;
  logic signed [PH_W-1:0]    ph_x_d, ph_x_q, ph_y_d, ph_y_q;
  logic signed [PL_W-1:0]    pl_x_d, pl_x_q, pl_y_d, pl_y_q;
  logic signed [COORD_W-1:0] z3_q;
  // stage 4
  logic signed [SUM_W-1:0]   sx_d, sx_q, sy_d, sy_q;
  logic signed [COORD_W-1:0] z4_q;
  // stage 5
  logic signed [SUM_W-1:0]   tx, ty, qx, qy;
  logic signed [COORD_W-1:0] x_d, x_q, y_d, y_q, z5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ce_q <= to_q20(el_i.x, el_flip_i);
      se_q <= to_q20(el_i.y, el_flip_i);
      ca_q <= to_q20(az_i.x, az_flip_i);
      sa_q <= to_q20(az_i.y, az_flip_i);
      r0_q <= range_i;
    end
  end

  always_comb begin
    r_s    = signed'({1'b0, r0_q});
    p_rc_d = PR_W'(r_s) * PR_W'(ce_q);
    p_z_d  = PR_W'(r_s) * PR_W'(se_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_rc_q <= p_rc_d;
      p_z_q  <= p_z_d;
      ca1_q  <= ca_q;
      sa1_q  <= sa_q;
    end
  end

  always_comb begin
    t_rc = p_rc_q[PR_W-1] ? p_rc_q + PR_W'(4'hF) : p_rc_q;
    rc_d = RC_W'(t_rc >>> 4);
    t_z  = p_z_q[PR_W-1] ? p_z_q + PR_W'({Z_SH{1'b1}}) : p_z_q;
    q_z  = t_z >>> Z_SH;
    z2_d = sat_coord(64'(q_z));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rc_q  <= rc_d;
      z2_q  <= z2_d;
      ca2_q <= ca1_q;
      sa2_q <= sa1_q;
    end
  end

  // Split the scaled range so each partial product stays narrow.
  always_comb begin
    rc_hi  = rc_q[RC_W-1:LO_W];
    rc_lo  = signed'({1'b0, rc_q[LO_W-1:0]});
    ph_x_d = PH_W'(rc_hi) * PH_W'(ca2_q);
    ph_y_d = PH_W'(rc_hi) * PH_W'(sa2_q);
    pl_x_d = PL_W'(rc_lo) * PL_W'(ca2_q);
    pl_y_d = PL_W'(rc_lo) * PL_W'(sa2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ph_x_q <= ph_x_d;
      ph_y_q <= ph_y_d;
      pl_x_q <= pl_x_d;
      pl_y_q <= pl_y_d;
      z3_q   <= z2_q;
    end
  end

  always_comb begin
    sx_d = (SUM_W'(ph_x_q) <<< LO_W) + SUM_W'(pl_x_q);
    sy_d = (SUM_W'(ph_y_q) <<< LO_W) + SUM_W'(pl_y_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      z4_q <= z3_q;
    end
  end

  always_comb begin
    tx  = sx_q[SUM_W-1] ? sx_q + SUM_W'({XY_SH{1'b1}}) : sx_q;
    ty  = sy_q[SUM_W-1] ? sy_q + SUM_W'({XY_SH{1'b1}}) : sy_q;
    qx  = tx >>> XY_SH;
    qy  = ty >>> XY_SH;
    x_d = sat_coord(64'(qx));
    y_d = sat_coord(64'(qy));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z5_q <= z4_q;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z5_q;

endmodule
